FILE: hw/rtl/prp_pkg.sv
`timescale 1ns / 1ps
package prp_pkg;

  // characters with a meaning in the record text
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_AT    = 8'h40;

  localparam logic [6:0] TIME_SCALE_RESET = 7'd10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } prp_in_t;

  typedef struct packed {
    logic [30:0]        code;
    logic signed [31:0] time_res;
    logic signed [31:0] unit;
    logic signed [31:0] origin;
  } prp_out_t;

endpackage

FILE: hw/rtl/punch_record_parser_top.sv
`timescale 1ns / 1ps
// Punch record parser: takes the text "code-time[.frac][@unit]...[#origin];" one
// character per request and returns one result per record, closed by ';' or by a
// character flagged last. One character is accepted every cycle unless a finished
// record is held back by out_ready. The closing character is parsed and the record
// frozen into snap_r; from snap_r the time is scaled by time_scale in the single
// 8 x 32 multiplier, saturated and registered in out_r. The user must write
// time_scale only while no record is in flight; the block does not enforce it.
module punch_record_parser_top
  import prp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  prp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output prp_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [6:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_CODE   = 3'd0,
    PH_TIME   = 3'd1,
    PH_FRAC   = 3'd2,
    PH_UNIT   = 3'd3,
    PH_ORIGIN = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ARG_SIGN   = 2'd0,
    ARG_DIGITS = 2'd1,
    ARG_SKIP   = 2'd2
  } arg_pos_t;

  typedef enum logic [1:0] {
    TM_ZERO = 2'd0,
    TM_BARE = 2'd1,
    TM_FRAC = 2'd2
  } time_mode_t;

  typedef struct packed {
    phase_t     phase;
    logic [31:0] code_acc;
    logic [31:0] time_acc;
    logic        time_neg;
    logic        time_digits_done;
    logic        time_seen;
    logic [6:0]  frac_value;
    logic [1:0]  frac_count;
    logic [31:0] unit_acc;
    logic        unit_neg;
    logic [31:0] origin_acc;
    logic        origin_neg;
    arg_pos_t    arg_pos;
    time_mode_t  time_mode;
  } rec_t;

  typedef struct packed {
    logic [31:0] acc;
    logic        neg;
    arg_pos_t    pos;
  } arg_t;

  typedef struct packed {
    logic [30:0]        code;
    logic signed [31:0] t;
    logic               minus_one;
    time_mode_t         mode;
    logic [6:0]         frac;
    logic               neg;
    logic signed [31:0] unit;
    logic signed [31:0] origin;
  } snap_t;

  localparam rec_t REC_CLEAR = rec_t'(0);

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // decimal accumulate, saturating at all ones
  function automatic logic [31:0] acc_digit(input logic [31:0] acc, input logic [7:0] c);
    logic [35:0] sum;
    sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, c[3:0]};
    return (|sum[35:32]) ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic logic signed [31:0] signed_of(input logic [31:0] mag, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      r = mag[31] ? 32'sh8000_0000 : $signed(32'd0 - mag);
    end else begin
      r = mag[31] ? 32'sh7FFF_FFFF : $signed(mag);
    end
    return r;
  endfunction

  function automatic rec_t after_time(input rec_t st, input logic [7:0] c);
    rec_t r;
    r = st;
    r.arg_pos = ARG_SIGN;
    if (c == CH_AT) begin
      r.phase = PH_UNIT;
    end else if (c == CH_HASH) begin
      r.phase = PH_ORIGIN;
    end else if (c == CH_SEMI || c == CH_NUL) begin
      r.phase = PH_DONE;
    end else begin
      r.phase   = PH_UNIT;
      r.arg_pos = ARG_SKIP;
    end
    return r;
  endfunction

  function automatic arg_t arg_char(input arg_pos_t pos, input logic [31:0] acc,
                                    input logic neg, input logic [7:0] c);
    arg_t a;
    a.acc = acc;
    a.neg = neg;
    a.pos = pos;
    case (pos)
      ARG_SIGN: begin
        if (c == CH_MINUS) begin
          a.neg = 1'b1;
          a.pos = ARG_DIGITS;
        end else if (c == CH_PLUS) begin
          a.pos = ARG_DIGITS;
        end else if (is_digit(c)) begin
          a.acc = acc_digit(acc, c);
          a.pos = ARG_DIGITS;
        end else begin
          a.pos = ARG_SKIP;
        end
      end
      ARG_DIGITS: begin
        if (is_digit(c)) a.acc = acc_digit(acc, c);
        else a.pos = ARG_SKIP;
      end
      default: ;
    endcase
    return a;
  endfunction

  // one character of the parse; the time itself is scaled only when the record closes
  function automatic rec_t step(input rec_t st, input logic [7:0] c, input logic [6:0] scale);
    rec_t               r;
    arg_t               a;
    logic               dig;
    logic signed [12:0] v;
    r   = st;
    dig = is_digit(c);
    v   = $signed({5'd0, c}) - 13'sd48;
    if (scale > 7'd10) v = (v <<< 3) + (v <<< 1);
    case (st.phase)
      PH_CODE: begin
        if (dig) begin
          r.code_acc = acc_digit(st.code_acc, c);
        end else if (c == CH_MINUS) begin
          r.phase = PH_TIME;
        end else begin
          r.time_mode = TM_ZERO;
          r = after_time(r, c);
        end
      end
      PH_TIME: begin
        if (dig || c == CH_MINUS) begin
          if (!st.time_seen) begin
            if (c == CH_MINUS) r.time_neg = 1'b1;
            else r.time_acc = acc_digit(st.time_acc, c);
            r.time_seen = 1'b1;
          end else if (c == CH_MINUS) begin
            r.time_digits_done = 1'b1;
          end else if (!st.time_digits_done) begin
            r.time_acc = acc_digit(st.time_acc, c);
          end
        end else if (scale > 7'd1 && c == CH_DOT) begin
          r.phase      = PH_FRAC;
          r.frac_count = 2'd0;
        end else begin
          r.time_mode = TM_BARE;
          r = after_time(r, c);
        end
      end
      PH_FRAC: begin
        if (st.frac_count == 2'd0) begin
          // keep only values that can ever land in range, else zero
          r.frac_value = (v > 13'sd0 && v < 13'sd128) ? v[6:0] : 7'd0;
          if (dig) begin
            r.frac_count = 2'd1;
          end else begin
            r.time_mode = TM_FRAC;
            r = after_time(r, c);
          end
        end else if (st.frac_count == 2'd1) begin
          if (scale >= 7'd100 && dig) r.frac_value = st.frac_value + {3'd0, c[3:0]};
          if (dig) begin
            r.frac_count = 2'd2;
          end else begin
            r.time_mode = TM_FRAC;
            r = after_time(r, c);
          end
        end else if (!dig) begin
          r.time_mode = TM_FRAC;
          r = after_time(r, c);
        end
      end
      PH_UNIT: begin
        if (c == CH_HASH) begin
          r.phase   = PH_ORIGIN;
          r.arg_pos = ARG_SIGN;
        end else if (c == CH_SEMI || c == CH_NUL) begin
          r.phase = PH_DONE;
        end else begin
          a = arg_char(st.arg_pos, st.unit_acc, st.unit_neg, c);
          r.unit_acc = a.acc;
          r.unit_neg = a.neg;
          r.arg_pos  = a.pos;
        end
      end
      PH_ORIGIN: begin
        if (c == CH_SEMI || c == CH_NUL) begin
          r.phase = PH_DONE;
        end else begin
          a = arg_char(st.arg_pos, st.origin_acc, st.origin_neg, c);
          r.origin_acc = a.acc;
          r.origin_neg = a.neg;
          r.arg_pos    = a.pos;
          if (a.pos == ARG_SKIP) r.phase = PH_DONE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  logic [6:0] scale_r;
  rec_t       rec_r, rec_nxt;
  rec_t       rec_c, rec_end;
  snap_t      snap_r, snap_nxt;
  logic       snap_v_r;
  prp_out_t   out_r, out_nxt;
  logic       out_v_r;

  logic in_acc, closes, out_adv, snap_adv;

  logic signed [39:0] prod;
  logic signed [40:0] tenth;
  logic signed [40:0] res;
  logic               tenth_ok;

  assign cfg_ready = 1'b1;
  assign out_adv   = !out_v_r || out_ready;
  assign snap_adv  = snap_v_r && out_adv;
  assign in_ready  = !snap_v_r || out_adv;
  assign in_acc    = in_valid && in_ready;
  assign closes    = (in_data.ch == CH_SEMI) || in_data.last;

  // a last character other than ';' runs one NUL through the parser before closing
  always_comb begin
    rec_c   = step(rec_r, in_data.ch, scale_r);
    rec_end = (in_data.ch == CH_SEMI) ? rec_c : step(rec_c, CH_NUL, scale_r);
    rec_nxt = closes ? REC_CLEAR : rec_c;

    snap_nxt.code      = rec_end.code_acc[31] ? 31'h7FFF_FFFF : rec_end.code_acc[30:0];
    snap_nxt.t         = signed_of(rec_end.time_acc, rec_end.time_neg);
    snap_nxt.minus_one = rec_end.time_neg && (rec_end.time_acc == 32'd1);
    snap_nxt.mode      = rec_end.time_mode;
    snap_nxt.frac      = rec_end.frac_value;
    snap_nxt.neg       = rec_end.time_neg;
    snap_nxt.unit      = signed_of(rec_end.unit_acc, rec_end.unit_neg);
    snap_nxt.origin    = signed_of(rec_end.origin_acc, rec_end.origin_neg);
  end

  // by mode: zero, scaled time or -1, or scaled time +/- fraction; saturate
  always_comb begin
    prod     = $signed({1'b0, scale_r}) * snap_r.t;
    tenth    = $signed({34'd0, snap_r.frac});
    tenth_ok = (snap_r.frac != 7'd0) && (snap_r.frac < scale_r);
    case (snap_r.mode)
      TM_ZERO: res = '0;
      TM_BARE: res = snap_r.minus_one ? -41'sd1 : {prod[39], prod};
      TM_FRAC: begin
        if (!tenth_ok) res = {prod[39], prod};
        else if (snap_r.neg) res = {prod[39], prod} - tenth;
        else res = {prod[39], prod} + tenth;
      end
      default: res = '0;
    endcase

    out_nxt.code   = snap_r.code;
    out_nxt.unit   = snap_r.unit;
    out_nxt.origin = snap_r.origin;
    if (!res[40] && (|res[39:31])) out_nxt.time_res = 32'sh7FFF_FFFF;
    else if (res[40] && !(&res[39:31])) out_nxt.time_res = 32'sh8000_0000;
    else out_nxt.time_res = res[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= TIME_SCALE_RESET;
      rec_r    <= REC_CLEAR;
      snap_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) scale_r <= cfg_data;
      if (in_acc) rec_r <= rec_nxt;
      if (in_acc && closes) snap_v_r <= 1'b1;
      else if (snap_adv) snap_v_r <= 1'b0;
      if (out_adv) out_v_r <= snap_v_r;
    end
    // payload: hold unless advancing
    if (in_acc && closes) snap_r <= snap_nxt;
    if (snap_adv) out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
